// ===== src/mrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus RTU response checker.
`default_nettype none

package mrc_pkg;

    localparam int MAX_FRAME = 256;
    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0] EXC_FLAG = 8'h80;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_CRC   = 2'd2,
        ST_EXC   = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  function_code;
        logic [7:0]  exception_code;
        logic [8:0]  frame_length;
        logic [15:0] computed_crc;
    } result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== src/mrc_frame_tracker.sv =====
// Per-frame state (CRC, delay line, byte count, header bytes) and the end-of-frame verdict.
`default_nettype none

module mrc_frame_tracker
    import mrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] byte_in,
    input  wire logic       last_in,
    output result_t         result
);

    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       d0_reg, d0_next;
    logic [7:0]       d1_reg, d1_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       func_reg, func_next;
    logic [7:0]       code_reg, code_next;
    logic [15:0]      rx_crc;
    status_t          status;

    always_comb
    begin
        crc_next = (count_reg >= CNT_W'(2)) ? crc_feed(crc_reg, d1_reg) : crc_reg;
        d1_next = d0_reg;
        d0_next = byte_in;
        func_next = (count_reg == CNT_W'(1)) ? byte_in : func_reg;
        code_next = (count_reg == CNT_W'(2)) ? byte_in : code_reg;
        count_next = (count_reg < CNT_W'(MAX_FRAME)) ? count_reg + CNT_W'(1)
                                                     : CNT_W'(MAX_FRAME);
        rx_crc = {byte_in, d0_reg};

        if (count_next < CNT_W'(4)) begin
            status = ST_SHORT;
        end else if (rx_crc != crc_next) begin
            status = ST_CRC;
        end else if (count_next >= CNT_W'(5) && (func_next & EXC_FLAG) != 8'h00) begin
            status = ST_EXC;
        end else begin
            status = ST_OK;
        end

        result.status = status;
        result.function_code = (count_next >= CNT_W'(2)) ? func_next : 8'h00;
        result.exception_code = (count_next >= CNT_W'(3)) ? code_next : 8'h00;
        result.frame_length = 9'(count_next);
        result.computed_crc = crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg <= CRC_INIT;
            d0_reg <= 8'h00;
            d1_reg <= 8'h00;
            count_reg <= '0;
            func_reg <= 8'h00;
            code_reg <= 8'h00;
        end else if (advance) begin
            if (last_in) begin
                crc_reg <= CRC_INIT;
                d0_reg <= 8'h00;
                d1_reg <= 8'h00;
                count_reg <= '0;
                func_reg <= 8'h00;
                code_reg <= 8'h00;
            end else begin
                crc_reg <= crc_next;
                d0_reg <= d0_next;
                d1_reg <= d1_next;
                count_reg <= count_next;
                func_reg <= func_next;
                code_reg <= code_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/mrc_result_reg.sv =====
// Output register holding one verdict until the receiver takes it.
`default_nettype none

module mrc_result_reg
    import mrc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result_in,
    output logic         space,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      result_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign out_valid = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire

// ===== src/modbus_rtu_response_checker_unit.sv =====
// Top level of the Modbus RTU response checker: input register, frame tracker, result register.
//
// Usage: frame bytes arrive on the input channel (in_valid/in_ready, rx_byte, last), one byte
// per transaction in wire order, with last set on the final byte of the frame. Each frame gives
// exactly one verdict transaction on the output channel (out_valid/out_ready) carrying status,
// function_code, exception_code, frame_length and computed_crc. Bytes without last give nothing.
// Throughput is one byte per cycle unless a final byte waits for room: the CRC-16 update of one
// byte is eight unrolled shift steps between the input register and the result register. A
// final byte is loaded from the input register into the result register, raising out_valid.
// The CRC covers all bytes except the trailing two, which are compared little-endian
// against it.
// Reset clears the frame state (CRC to 0xFFFF, count and header bytes to zero) and empties both
// registers. While the receiver stalls, the verdict holds in the result register; bytes that are
// not final keep flowing, and a final byte waits in the input register until the result
// register has room, with in_ready held low for as long as it waits.
`default_nettype none

module modbus_rtu_response_checker_unit
    import mrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [7:0]       function_code,
    output logic [7:0]       exception_code,
    output logic [8:0]       frame_length,
    output logic [15:0]      computed_crc
);

    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_byte_reg;
    logic       hold_last_reg;
    logic       space;
    logic       advance;
    logic       load;
    result_t    verdict;
    result_t    result_out;

    assign advance = hold_valid_reg && (!hold_last_reg || space);
    assign load = advance && hold_last_reg;
    assign in_ready = !hold_valid_reg || advance;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready) begin
            hold_valid_next = 1'b1;
        end else if (advance) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            hold_byte_reg <= rx_byte;
            hold_last_reg <= last;
        end
    end

    mrc_frame_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_in (hold_byte_reg),
        .last_in (hold_last_reg),
        .result  (verdict)
    );

    mrc_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .result_in  (verdict),
        .space      (space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_out)
    );

    assign status = result_out.status;
    assign function_code = result_out.function_code;
    assign exception_code = result_out.exception_code;
    assign frame_length = result_out.frame_length;
    assign computed_crc = result_out.computed_crc;

    a_verdict_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("Final byte did not produce a verdict.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !load)
        else $error("Verdict overwritten while the receiver stalls.");

    a_final_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && hold_last_reg && out_valid && !out_ready |-> !in_ready)
        else $error("Input accepted while a final byte is blocked.");

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK || status == ST_CRC) |-> frame_length >= 9'd4)
        else $error("Checked verdict on a frame shorter than four bytes.");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the Modbus RTU response checker: frame stimulus and verdict checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 400;
    localparam int SETTLE_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [7:0]  function_code;
    logic [7:0]  exception_code;
    logic [8:0]  frame_length;
    logic [15:0] computed_crc;

    bit idle_en = 1'b1;
    bit stall_en = 1'b1;
    int hold_req = 0;
    int err_cnt = 0;
    int items_sent = 0;
    int cycles = 0;

    logic [15:0] run_crc = CRC_INIT;
    logic [7:0]  newest_byte = 8'h00;
    logic [7:0]  older_byte = 8'h00;
    logic [8:0]  frame_bytes = '0;
    logic [7:0]  func_seen = 8'h00;
    logic [7:0]  code_seen = 8'h00;

    result_t     pending_verdicts[$];
    logic [7:0]  frame_buf[$];

    modbus_rtu_response_checker_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .function_code(function_code),
        .exception_code(exception_code),
        .frame_length(frame_length),
        .computed_crc(computed_crc)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[modbus_rtu_response_checker_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = acc[0] ^ data[i];
            acc = acc >> 1;
            if (fb)
            begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    task automatic track_frame_byte(input logic [7:0] data, input logic is_last);
        logic [8:0]  len;
        logic [15:0] trailer;
        result_t     v;
        if (frame_bytes >= 2)
        begin
            run_crc = crc16_step(run_crc, older_byte);
        end
        older_byte = newest_byte;
        newest_byte = data;
        if (frame_bytes == 1)
        begin
            func_seen = data;
        end
        if (frame_bytes == 2)
        begin
            code_seen = data;
        end
        len = (frame_bytes < MAX_FRAME) ? frame_bytes + 9'd1 : 9'(MAX_FRAME);
        frame_bytes = len;
        if (is_last)
        begin
            trailer = {newest_byte, older_byte};
            if (len < 4)
            begin
                v.status = ST_SHORT;
            end
            else if (trailer != run_crc)
            begin
                v.status = ST_CRC;
            end
            else if (len >= 5 && (func_seen & EXC_FLAG) != 8'h00)
            begin
                v.status = ST_EXC;
            end
            else
            begin
                v.status = ST_OK;
            end
            v.function_code = (len >= 2) ? func_seen : 8'h00;
            v.exception_code = (len >= 3) ? code_seen : 8'h00;
            v.frame_length = len;
            v.computed_crc = run_crc;
            pending_verdicts = {pending_verdicts, v};
            run_crc = CRC_INIT;
            newest_byte = 8'h00;
            older_byte = 8'h00;
            frame_bytes = '0;
            func_seen = 8'h00;
            code_seen = 8'h00;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict transaction with no frame pending");
                err_cnt++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    err_cnt++;
                end
                if (function_code !== want.function_code)
                begin
                    $error("function_code: expected %0h, actual %0h",
                           want.function_code, function_code);
                    err_cnt++;
                end
                if (exception_code !== want.exception_code)
                begin
                    $error("exception_code: expected %0h, actual %0h",
                           want.exception_code, exception_code);
                    err_cnt++;
                end
                if (frame_length !== want.frame_length)
                begin
                    $error("frame_length: expected %0d, actual %0d",
                           want.frame_length, frame_length);
                    err_cnt++;
                end
                if (computed_crc !== want.computed_crc)
                begin
                    $error("computed_crc: expected %0h, actual %0h",
                           want.computed_crc, computed_crc);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin : receiver
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                n = hold_req;
                hold_req = 0;
                out_ready <= 1'b0;
            end
            else if (stall_en && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 4);
                out_ready <= 1'b0;
            end
            else
            begin
                n = $urandom_range(1, 6);
                out_ready <= 1'b1;
            end
            repeat (n - 1) @(negedge clk);
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic is_last);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte <= data;
        last <= is_last;
        do @(posedge clk); while (!in_ready);
        track_frame_byte(data, is_last);
        items_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            push_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    task automatic fill_random(input int n);
        frame_buf.delete();
        repeat (n) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    endtask

    task automatic append_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[i])
        begin
            c = crc16_step(c, frame_buf[i]);
        end
        frame_buf = {frame_buf, c[7:0], c[15:8]};
    endtask

    task automatic send_random_frame();
        int pick;
        int n;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            fill_random($urandom_range(1, 10));
        end
        else
        begin
            if (pick < 85)
            begin
                n = $urandom_range(0, 6);
            end
            else if (pick < 97)
            begin
                n = $urandom_range(7, 30);
            end
            else
            begin
                n = $urandom_range(31, 80);
            end
            fill_random(n);
            append_crc();
            if (pick >= 70 && pick < 85)
            begin
                idx = $urandom_range(0, frame_buf.size() - 1);
                frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        send_frame();
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_frames();
        frame_buf = '{8'hFF};
        send_frame();
        frame_buf = '{8'h00, 8'hFF};
        send_frame();
        frame_buf = '{8'h01, 8'h83, 8'h7F};
        send_frame();
        frame_buf = '{8'h11, 8'h83};
        append_crc();
        send_frame();
        frame_buf = '{8'h01, 8'h83, 8'h02};
        append_crc();
        send_frame();
        frame_buf = '{8'h01, 8'h83, 8'h02};
        append_crc();
        frame_buf[4] = frame_buf[4] ^ 8'h01;
        send_frame();
        frame_buf = '{8'hFF, 8'h7F, 8'h00};
        append_crc();
        send_frame();
        drain();
    endtask

    task automatic test_long_frames();
        fill_random(MAX_FRAME - 1);
        append_crc();
        send_frame();
        fill_random(MAX_FRAME + 1);
        append_crc();
        frame_buf[100] = frame_buf[100] ^ 8'h40;
        send_frame();
        drain();
    endtask

    task automatic test_random_traffic();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            send_random_frame();
        end
        drain();
    endtask

    task automatic test_output_stall();
        idle_en = 1'b0;
        hold_req = 300;
        repeat (20) send_random_frame();
        idle_en = 1'b1;
        drain();
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        stall_en = 1'b0;
        repeat (50) send_random_frame();
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_frames();
        test_long_frames();
        test_random_traffic();
        test_output_stall();
        test_full_rate();
        if (pending_verdicts.size() != 0)
        begin
            $error("%0d verdicts never arrived", pending_verdicts.size());
            err_cnt++;
        end
        if (err_cnt == 0)
        begin
            $display("[modbus_rtu_response_checker_unit] OK");
        end
        else
        begin
            $display("[modbus_rtu_response_checker_unit] ERROR");
        end
        $finish;
    end

endmodule
